FILE: design/tcc_pkg.sv
// Shared types and constants of the text console cursor engine.
package tcc_pkg;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_WRITE = 2'd1,
    OP_CLEAR = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_SCROLL,
    ST_FILL,
    ST_FIN
  } state_t;

  localparam logic [7:0] RESET_COLOR = 8'h07;
  localparam logic [7:0] BLANK_CHAR  = 8'h20;
  localparam logic [7:0] CH_BS       = 8'h08;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] TAB_STEP    = 8'd8;
  localparam logic [7:0] TAB_MASK    = 8'hF8;

  typedef struct packed {
    op_t        operation;
    logic [7:0] character;
    logic [6:0] column;
    logic [4:0] row;
    logic [7:0] cell_color;
  } in_item_t;

  typedef struct packed {
    logic [15:0] cell_value;
    logic [6:0]  cursor_column;
    logic [4:0]  cursor_row;
  } out_item_t;

endpackage

FILE: design/tcc_in_if.sv
// Valid/ready channel that carries console operation items.
interface tcc_in_if;
  logic               valid;
  logic               ready;
  tcc_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: design/tcc_out_if.sv
// Valid/ready channel that carries console result items.
interface tcc_out_if;
  logic               valid;
  logic               ready;
  tcc_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: design/tcc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tcc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/text_console_cursor_engine.sv
// Text console cursor engine: cell store, cursor control, scroll and clear sequencer.
// The block holds ROWS by COLUMNS cells of 16 bits in one RAM with one write and one
// registered read port, and takes one item at a time. A put character or cell write
// passes through the EXEC and FIN states before its result is presented, a cell read
// through EXEC, READ and FIN. A put that scrolls walks the whole store once, moving each
// cell up one row and blanking the bottom row; a clear blanks the whole store. Both walks
// handle one cell per cycle through the single write port. After reset the block blanks
// all ROWS*COLUMNS cells (2000 at the defaults) before it takes its first item; color
// writes on cfg_we are taken during that pass. The next item may be accepted while the
// previous result still waits on the output.
module text_console_cursor_engine #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic       clk,
  input  logic       rst_n,
  tcc_in_if.sink     in_ch,
  tcc_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);
  import tcc_pkg::*;

  localparam int CELLS       = COLUMNS * ROWS;
  localparam int AW          = $clog2(CELLS);
  localparam int SW          = $clog2(CELLS + 1);
  localparam int SCROLL_LAST = CELLS - COLUMNS;

  localparam logic [7:0]    COLS8    = 8'(COLUMNS);
  localparam logic [5:0]    ROWS6    = 6'(ROWS);
  localparam logic [5:0]    ROW_LAST = 6'(ROWS - 1);
  localparam logic [SW-1:0] CNT_END  = SW'(CELLS);
  localparam logic [SW-1:0] CNT_FILL = SW'(CELLS - 1);
  localparam logic [SW-1:0] CNT_MOVE = SW'(SCROLL_LAST);

  state_t      state_r, state_nxt;
  logic [7:0]  color_r, color_nxt;
  logic [6:0]  cur_col_r, cur_col_nxt;
  logic [4:0]  cur_row_r, cur_row_nxt;
  in_item_t    item_r, item_nxt;
  logic [SW-1:0] cnt_r, cnt_nxt;
  logic [7:0]  fill_color_r, fill_color_nxt;
  logic [15:0] val_r, val_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_data_r, out_data_nxt;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [15:0]   ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [15:0]   rd_q;

  logic          in_acc;
  logic          out_free;
  logic          pos_ok;
  logic [AW-1:0] pos_addr;
  logic [7:0]    col8, pc;
  logic [5:0]    pr;
  logic [6:0]    wcol;
  logic          pwe;
  logic [7:0]    pchar;
  logic          put_scroll;
  logic [AW-1:0] put_addr;

  tcc_ram #(.WIDTH(16), .DEPTH(CELLS)) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd_q)
  );

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;
  assign out_free     = !out_valid_r || out_ch.ready;

  assign pos_ok   = ({1'b0, item_r.column} < COLS8) && ({1'b0, item_r.row} < ROWS6);
  assign pos_addr = AW'(int'(item_r.row) * COLUMNS + int'(item_r.column));
  assign col8     = {1'b0, cur_col_r};

  // Cursor movement and cell write of a put character.
  always_comb begin
    pc    = col8;
    pr    = {1'b0, cur_row_r};
    pwe   = 1'b0;
    pchar = item_r.character;
    wcol  = cur_col_r;
    case (item_r.character)
      CH_LF: begin
        pc = 8'd0;
        pr = pr + 6'd1;
      end
      CH_CR: begin
        pc = 8'd0;
      end
      CH_TAB: begin
        pc = (col8 + TAB_STEP) & TAB_MASK;
      end
      CH_BS: begin
        if (cur_col_r != 7'd0) begin
          pc = col8 - 8'd1;
        end
        pwe   = 1'b1;
        pchar = BLANK_CHAR;
        wcol  = pc[6:0];
      end
      default: begin
        pwe = 1'b1;
        pc  = col8 + 8'd1;
      end
    endcase
    if (pc >= COLS8) begin
      pc = 8'd0;
      pr = pr + 6'd1;
    end
    put_scroll = (pr >= ROWS6);
    if (put_scroll) begin
      pr = ROW_LAST;
    end
    put_addr = AW'(int'(cur_row_r) * COLUMNS + int'(wcol));
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_INIT: begin
        if (cnt_r == CNT_FILL) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (item_r.operation)
          OP_PUT:   state_nxt = put_scroll ? ST_SCROLL : ST_FIN;
          OP_CLEAR: state_nxt = ST_FILL;
          OP_READ:  state_nxt = ST_READ;
          default:  state_nxt = ST_FIN;
        endcase
      end
      ST_READ: begin
        state_nxt = ST_FIN;
      end
      ST_SCROLL: begin
        if (cnt_r == CNT_END) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FILL: begin
        if (cnt_r == CNT_FILL) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    color_nxt      = cfg_we ? cfg_wdata : color_r;
    cur_col_nxt    = cur_col_r;
    cur_row_nxt    = cur_row_r;
    item_nxt       = in_acc ? in_ch.data : item_r;
    cnt_nxt        = cnt_r;
    fill_color_nxt = fill_color_r;
    val_nxt        = val_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_data_nxt   = out_data_r;
    ram_we         = 1'b0;
    ram_waddr      = put_addr;
    ram_wdata      = {fill_color_r, BLANK_CHAR};
    ram_raddr      = pos_addr;
    case (state_r)
      ST_INIT, ST_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r[AW-1:0];
        cnt_nxt   = cnt_r + SW'(1);
      end
      ST_EXEC: begin
        val_nxt        = 16'd0;
        cnt_nxt        = '0;
        fill_color_nxt = color_r;
        case (item_r.operation)
          OP_PUT: begin
            ram_we      = pwe;
            ram_wdata   = {color_r, pchar};
            cur_col_nxt = pc[6:0];
            cur_row_nxt = pr[4:0];
          end
          OP_WRITE: begin
            ram_we    = pos_ok;
            ram_waddr = pos_addr;
            ram_wdata = {item_r.cell_color, item_r.character};
          end
          OP_CLEAR: begin
            cur_col_nxt = 7'd0;
            cur_row_nxt = 5'd0;
          end
          default: begin
            ram_raddr = pos_addr;
          end
        endcase
      end
      ST_READ: begin
        val_nxt = pos_ok ? rd_q : 16'd0;
      end
      ST_SCROLL: begin
        if (int'(cnt_r) + COLUMNS < CELLS) begin
          ram_raddr = AW'(int'(cnt_r) + COLUMNS);
        end else begin
          ram_raddr = '0;
        end
        ram_we    = (cnt_r != '0);
        ram_waddr = AW'(cnt_r - SW'(1));
        if (cnt_r <= CNT_MOVE) begin
          ram_wdata = rd_q;
        end
        cnt_nxt = cnt_r + SW'(1);
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{cell_value: val_r, cursor_column: cur_col_r,
                            cursor_row: cur_row_r};
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_INIT;
      color_r      <= RESET_COLOR;
      cur_col_r    <= 7'd0;
      cur_row_r    <= 5'd0;
      cnt_r        <= '0;
      fill_color_r <= RESET_COLOR;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      color_r      <= color_nxt;
      cur_col_r    <= cur_col_nxt;
      cur_row_r    <= cur_row_nxt;
      cnt_r        <= cnt_nxt;
      fill_color_r <= fill_color_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    val_r      <= val_nxt;
    out_data_r <= out_data_nxt;
  end

  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, cur_row_r} < ROWS6)
    else $error("cursor row out of range");

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, cur_col_r} < COLS8)
    else $error("cursor column out of range");

  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r != ST_IDLE))
    else $error("cell store written while idle");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ch.ready)
    else $error("input ready while an item is in work");

  a_fin_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN) |=> (state_r == ST_IDLE) || (state_r == ST_FIN))
    else $error("result stage left to a working state");

endmodule
